// File: rtl/fgce_pkg.sv
// Shared types and constants for the footprint grid cell enumerator.
`timescale 1ns / 1ps
`default_nettype none
package fgce_pkg;
    localparam int unsigned CoordW = 64;
    localparam int unsigned CellW  = 32;
    localparam int unsigned HandleW = 32;

    localparam logic [1:0] CfgCellSize = 2'd0;
    localparam logic [1:0] CfgOriginX  = 2'd1;
    localparam logic [1:0] CfgOriginY  = 2'd2;

    // Job handed from the front part to the enumerator.
    typedef struct packed {
        logic signed [CellW-1:0] min_x;
        logic signed [CellW-1:0] min_y;
        logic [3:0]              span_x;
        logic [3:0]              span_y;
        logic [HandleW-1:0]      owner_index;
        logic [HandleW-1:0]      owner_generation;
        logic                    clipped;
    } t_job;
endpackage
`default_nettype wire

// File: rtl/fgce_div.sv
// Sequential signed floor divider, one quotient bit per cycle, 32-bit low quotient out.
`timescale 1ns / 1ps
`default_nettype none
module fgce_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_num,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_den,
    output logic                                    o_done,
    output logic signed [fgce_pkg::CellW-1:0]       o_quot
);
    localparam int unsigned W = fgce_pkg::CoordW;

    logic          r_busy;
    logic [6:0]    r_cnt;
    logic [W-1:0]  r_q;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_den;
    logic          r_neg;
    logic          r_done;
    logic [W:0]    n_rem_sh;
    logic [W:0]    n_sub;
    logic [W-1:0]  n_qf;

    // The numerator is taken as a magnitude; the denominator is positive.
    always_comb begin
        n_rem_sh = {r_rem[W-1:0], r_q[W-1]};
        n_sub    = n_rem_sh - {1'b0, r_den};
        // floor: negative with remainder gives -(q+1), else -q
        if (r_neg) begin
            n_qf = (r_rem != '0) ? ~r_q : (~r_q + 1'b1);
        end else begin
            n_qf = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(W);
                r_neg  <= i_num[W-1];
                r_q    <= i_num[W-1] ? (~i_num + 1'b1) : i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_sub[W]) begin
                    r_rem <= n_sub;
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem_sh;
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Result is registered once more so the floor correction sits off the loop.
    logic r_out_done;
    logic signed [fgce_pkg::CellW-1:0] r_quot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_done <= 1'b0;
        end else begin
            r_out_done <= r_done;
        end
        if (r_done) begin
            r_quot <= n_qf[fgce_pkg::CellW-1:0];
        end
    end
    assign o_done = r_out_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// File: rtl/fgce_front.sv
// Front part: accepts colliders, runs up to four floor divisions, builds an enumeration job.
`timescale 1ns / 1ps
`default_nettype none
module fgce_front #(
    parameter int unsigned MAX_SPAN = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [fgce_pkg::HandleW-1:0]       i_handle_index,
    input  wire logic [fgce_pkg::HandleW-1:0]       i_handle_generation,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_pos_x,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_pos_y,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_bound_radius,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_cell_size,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_origin_x,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_origin_y,
    output logic                                    o_job_valid,
    output fgce_pkg::t_job                          o_job,
    input  wire logic                               i_job_full
);
    localparam int unsigned W = fgce_pkg::CoordW;
    localparam int unsigned C = fgce_pkg::CellW;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0]          r_state;
    logic [1:0]          r_step;
    logic [W-1:0]        r_px, r_py, r_rad, r_size, r_ox, r_oy;
    logic                r_center;
    logic [C-1:0]        r_res [4];
    logic [fgce_pkg::HandleW-1:0] r_idx, r_gen;
    fgce_pkg::t_job      r_job;
    logic                r_keep;

    logic                n_start;
    logic signed [W-1:0] n_num;
    logic                div_done;
    logic signed [C-1:0] div_q;
    logic [W-1:0]        n_coord;

    // Step order: min x, max x, min y, max y.
    always_comb begin
        unique case (r_step)
            2'd0: n_coord = r_center ? r_px : r_px - r_rad;
            2'd1: n_coord = r_px + r_rad;
            2'd2: n_coord = r_center ? r_py : r_py - r_rad;
            default: n_coord = r_py + r_rad;
        endcase
        n_num   = n_coord - (r_step[1] ? r_oy : r_ox);
        n_start = (r_state == S_DIV);
    end

    fgce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_num   (n_num),
        .i_den   (r_size),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Span evaluation from the registered quotients.
    logic signed [C:0] n_dx, n_dy;
    logic              n_clip_x, n_clip_y;
    always_comb begin
        n_dx = {r_res[1][C-1], r_res[1]} - {r_res[0][C-1], r_res[0]};
        n_dy = {r_res[3][C-1], r_res[3]} - {r_res[2][C-1], r_res[2]};
        n_clip_x = n_dx >= (C+1)'(MAX_SPAN);
        n_clip_y = n_dy >= (C+1)'(MAX_SPAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_keep  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_px     <= i_pos_x;
                        r_py     <= i_pos_y;
                        r_rad    <= i_bound_radius;
                        r_center <= (i_bound_radius <= 0);
                        r_size   <= i_cell_size;
                        r_ox     <= i_origin_x;
                        r_oy     <= i_origin_y;
                        r_idx    <= i_handle_index;
                        r_gen    <= i_handle_generation;
                        r_step   <= '0;
                        r_state  <= (i_cell_size > 0) ? S_DIV : S_IDLE;
                    end
                end
                S_DIV: r_state <= S_WAIT;
                S_WAIT: begin
                    if (div_done) begin
                        r_res[r_step] <= div_q;
                        if (r_center && r_step == 2'd0) begin
                            r_res[1] <= div_q;
                        end
                        if (r_center && r_step == 2'd2) begin
                            r_res[3] <= div_q;
                        end
                        if (r_step == 2'd3 || (r_center && r_step == 2'd2)) begin
                            r_state <= S_EVAL;
                        end else begin
                            r_step  <= r_center ? 2'd2 : r_step + 2'd1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_EVAL: begin
                    r_keep               <= !n_dx[C] && !n_dy[C];
                    r_job.min_x          <= r_res[0];
                    r_job.min_y          <= r_res[2];
                    r_job.span_x         <= n_clip_x ? 4'(MAX_SPAN) : 4'(n_dx) + 4'd1;
                    r_job.span_y         <= n_clip_y ? 4'(MAX_SPAN) : 4'(n_dy) + 4'd1;
                    r_job.clipped        <= n_clip_x || n_clip_y;
                    r_job.owner_index    <= r_idx;
                    r_job.owner_generation <= r_gen;
                    r_state              <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_keep || !i_job_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_PUSH) && r_keep && !i_job_full;
    assign o_job       = r_job;
endmodule
`default_nettype wire

// File: rtl/fgce_back.sv
// Back part: two-entry job queue and the row-major cell enumerator with output register.
`timescale 1ns / 1ps
`default_nettype none
module fgce_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_valid,
    input  wire fgce_pkg::t_job                i_job,
    output logic                               o_job_full,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [fgce_pkg::CellW-1:0]  o_cell_x,
    output logic signed [fgce_pkg::CellW-1:0]  o_cell_y,
    output logic [fgce_pkg::HandleW-1:0]       o_owner_index,
    output logic [fgce_pkg::HandleW-1:0]       o_owner_generation,
    output logic                               o_span_clipped,
    output logic                               o_last_cell
);
    fgce_pkg::t_job r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic [3:0]     r_i, r_j;
    logic           r_ov;
    logic           n_pop, n_load;
    logic           n_last;
    fgce_pkg::t_job n_head;

    assign n_head = r_q[r_rp];
    assign n_last = (r_i == n_head.span_x - 4'd1) && (r_j == n_head.span_y - 4'd1);
    assign n_load = (r_cnt != 2'd0) && (!r_ov || !i_stall);
    assign n_pop  = n_load && n_last;
    assign o_job_full = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
            r_i   <= '0;
            r_j   <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_job_valid) begin
                r_q[r_wp] <= i_job;
                r_wp      <= ~r_wp;
            end
            r_cnt <= r_cnt + {1'b0, i_job_valid} - {1'b0, n_pop};
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (n_load) begin
                r_ov               <= 1'b1;
                o_cell_x           <= n_head.min_x + 32'(r_i);
                o_cell_y           <= n_head.min_y + 32'(r_j);
                o_owner_index      <= n_head.owner_index;
                o_owner_generation <= n_head.owner_generation;
                o_span_clipped     <= n_head.clipped;
                o_last_cell        <= n_last;
                if (n_last) begin
                    r_i  <= '0;
                    r_j  <= '0;
                    r_rp <= ~r_rp;
                end else if (r_i == n_head.span_x - 4'd1) begin
                    r_i <= '0;
                    r_j <= r_j + 4'd1;
                end else begin
                    r_i <= r_i + 4'd1;
                end
            end
        end
    end
    assign o_valid = r_ov;
endmodule
`default_nettype wire

// File: rtl/footprint_grid_cell_enumerator.sv
// Top level of the footprint grid cell enumerator.
`timescale 1ns / 1ps
`default_nettype none
// Takes one collider request at a time (handle, Q32.32 centre and radius) and emits one
// result request per covered grid cell, row-major with y outer and x inner, with last_cell
// on the final one, at most MAX_SPAN cells per axis. The front part runs up to four floor
// divisions, one after another, on a shared one-bit-per-cycle divider (two in the
// centre-cell case, four for a positive radius); the collider's job then enters a
// two-entry queue, and the back part emits one cell per cycle while the output is not
// stalled. The input stalls while the front works on a collider. A cell size at or below
// zero drops the collider at the accepting edge, and the input is free again in the next
// cycle. Configuration writes are always ready and must only be made while the block is
// idle.
module footprint_grid_cell_enumerator #(
    parameter int unsigned MAX_SPAN = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [fgce_pkg::HandleW-1:0]       i_handle_index,
    input  wire logic [fgce_pkg::HandleW-1:0]       i_handle_generation,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_pos_x,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_pos_y,
    input  wire logic signed [fgce_pkg::CoordW-1:0] i_bound_radius,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [fgce_pkg::CoordW-1:0]        i_cfg_data,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [fgce_pkg::CellW-1:0]       o_cell_x,
    output logic signed [fgce_pkg::CellW-1:0]       o_cell_y,
    output logic [fgce_pkg::HandleW-1:0]            o_owner_index,
    output logic [fgce_pkg::HandleW-1:0]            o_owner_generation,
    output logic                                    o_span_clipped,
    output logic                                    o_last_cell
);
    // Configuration registers; reset to zero, which disables output.
    logic signed [fgce_pkg::CoordW-1:0] r_cell_size, r_origin_x, r_origin_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= '0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fgce_pkg::CfgCellSize: r_cell_size <= i_cfg_data;
                fgce_pkg::CfgOriginX:  r_origin_x  <= i_cfg_data;
                fgce_pkg::CfgOriginY:  r_origin_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic           job_valid, job_full;
    fgce_pkg::t_job job;

    fgce_front #(.MAX_SPAN(MAX_SPAN)) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_bound_radius      (i_bound_radius),
        .i_cell_size         (r_cell_size),
        .i_origin_x          (r_origin_x),
        .i_origin_y          (r_origin_y),
        .o_job_valid         (job_valid),
        .o_job               (job),
        .i_job_full          (job_full)
    );

    fgce_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job_valid        (job_valid),
        .i_job              (job),
        .o_job_full         (job_full),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_cell_x           (o_cell_x),
        .o_cell_y           (o_cell_y),
        .o_owner_index      (o_owner_index),
        .o_owner_generation (o_owner_generation),
        .o_span_clipped     (o_span_clipped),
        .o_last_cell        (o_last_cell)
    );

`ifndef ASSERT_OFF
    // The queue never takes a job while it is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_full |-> !job_valid) else $error("job queue overflow");
    // A result held under stall keeps its last-cell flag.
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_last_cell)) else $error("last flag moved");
    // A job enters only while the front is busy with a collider.
    a_job_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> o_stall) else $error("job without collider");
`endif
endmodule
`default_nettype wire
